// File: rtl/bpq_pkg.sv
// Shared constants, codes and controller-to-datapath types of the bucket priority queue.
`timescale 1ns / 1ps

package bpq_pkg;

  localparam int NUM_ELEMENTS   = 1024;
  localparam int NUM_PRIORITIES = 64;
  localparam int ELEM_W = 10;
  localparam int LINK_W = 11;
  localparam int PRIO_W = 6;
  localparam int EB_W   = 7;
  localparam int CNT_W  = 11;

  // Link value that marks the end of a bucket list.
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_ELEMENTS);
  // Bucket value of an element that is not queued.
  localparam logic [EB_W-1:0] NIL_BUCKET = EB_W'(NUM_PRIORITIES);

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_UPDATE  = 3'd2,
    REQ_EXT_MIN = 3'd3,
    REQ_EXT_MAX = 3'd4,
    REQ_EXT_AT  = 3'd5,
    REQ_QUERY   = 3'd6,
    REQ_NONE    = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_QUEUED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_AT  = 2'd0,
    SRC_MIN = 2'd1,
    SRC_MAX = 2'd2
  } src_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    src_sel_t src_sel;
    logic     decide;
    logic     ul_head;
    status_t  st;
    logic     ul_read;
    logic     ul_write;
    logic     lk_read;
    logic     lk_write;
    logic     clr_write;
    logic     load_out;
  } bpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_queued;
    logic pr_ok;
    logic src_empty;
    logic clear_done;
    logic out_busy;
  } bpq_stat_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [PRIO_W-1:0] lowest_set(input logic [NUM_PRIORITIES-1:0] bm);
    logic [PRIO_W-1:0] r;
    r = '0;
    for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
      if (bm[i]) r = PRIO_W'(i);
    end
    return r;
  endfunction

  // Index of the highest set bit; zero when none is set.
  function automatic logic [PRIO_W-1:0] highest_set(input logic [NUM_PRIORITIES-1:0] bm);
    logic [PRIO_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_PRIORITIES; i++) begin
      if (bm[i]) r = PRIO_W'(i);
    end
    return r;
  endfunction

endpackage

// File: rtl/bpq_ctrl.sv
// Sequencing state machine of the bucket priority queue.
`timescale 1ns / 1ps

module bpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  bpq_pkg::bpq_stat_t stat,
  output bpq_pkg::bpq_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_LOOK  = 8'b00000100,
    S_UL1   = 8'b00001000,
    S_UL2   = 8'b00010000,
    S_LK1   = 8'b00100000,
    S_LK2   = 8'b01000000,
    S_RES   = 8'b10000000
  } state_t;

  state_t        state, state_next;
  bpq_pkg::req_t req;
  logic          lk_pend, lk_pend_next;

  // Plan taken in the look-up state.
  logic            do_ul, do_lk, ul_head;
  bpq_pkg::status_t st;

  always_comb begin
    do_ul   = 1'b0;
    do_lk   = 1'b0;
    ul_head = 1'b0;
    st      = bpq_pkg::ST_OK;
    case (req)
      bpq_pkg::REQ_INSERT: begin
        if (!stat.pr_ok) st = bpq_pkg::ST_RANGE;
        else if (stat.id_queued) st = bpq_pkg::ST_QUEUED;
        else do_lk = 1'b1;
      end
      bpq_pkg::REQ_REMOVE: begin
        do_ul = stat.id_queued;
      end
      bpq_pkg::REQ_UPDATE: begin
        if (!stat.pr_ok) st = bpq_pkg::ST_RANGE;
        else begin
          do_ul = stat.id_queued;
          do_lk = 1'b1;
        end
      end
      bpq_pkg::REQ_EXT_MIN, bpq_pkg::REQ_EXT_MAX: begin
        if (stat.src_empty) st = bpq_pkg::ST_EMPTY;
        else begin
          do_ul   = 1'b1;
          ul_head = 1'b1;
        end
      end
      bpq_pkg::REQ_EXT_AT: begin
        if (!stat.pr_ok) st = bpq_pkg::ST_RANGE;
        else if (stat.src_empty) st = bpq_pkg::ST_EMPTY;
        else begin
          do_ul   = 1'b1;
          ul_head = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    lk_pend_next = lk_pend;
    cmd          = '0;
    cmd.src_sel  = bpq_pkg::SRC_AT;
    in_stall     = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clear_done) begin
          cmd.clr_write = 1'b0;
          state_next    = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (req_type == bpq_pkg::REQ_EXT_MIN) cmd.src_sel = bpq_pkg::SRC_MIN;
        else if (req_type == bpq_pkg::REQ_EXT_MAX) cmd.src_sel = bpq_pkg::SRC_MAX;
        if (in_valid) state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.decide   = 1'b1;
        cmd.ul_head  = ul_head;
        cmd.st       = st;
        lk_pend_next = do_lk;
        if (do_ul) state_next = S_UL1;
        else if (do_lk) state_next = S_LK1;
        else state_next = S_RES;
      end
      S_UL1: begin
        cmd.ul_read = 1'b1;
        state_next  = S_UL2;
      end
      S_UL2: begin
        cmd.ul_write = 1'b1;
        state_next   = lk_pend ? S_LK1 : S_RES;
      end
      S_LK1: begin
        cmd.lk_read = 1'b1;
        state_next  = S_LK2;
      end
      S_LK2: begin
        cmd.lk_write = 1'b1;
        state_next   = S_RES;
      end
      S_RES: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      lk_pend <= 1'b0;
    end else begin
      state   <= state_next;
      lk_pend <= lk_pend_next;
    end
  end

  // Request code of the item at work.
  always_ff @(posedge clk) begin
    if (cmd.capture) req <= bpq_pkg::req_t'(req_type);
  end

endmodule

// File: rtl/bpq_datapath.sv
// Bucket lists, element table, occupancy bitmap and result register of the queue.
`timescale 1ns / 1ps

module bpq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bpq_pkg::ELEM_W-1:0]   element_id,
  input  logic [bpq_pkg::PRIO_W-1:0]   priority_value,
  input  logic                         cfg_valid,
  input  logic [bpq_pkg::PRIO_W-1:0]   cfg_data,
  input  bpq_pkg::bpq_cmd_t            cmd,
  output bpq_pkg::bpq_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bpq_pkg::ELEM_W-1:0]   result_element,
  output logic                         result_valid,
  output logic [bpq_pkg::PRIO_W-1:0]   element_priority,
  output logic                         element_queued,
  output logic [bpq_pkg::CNT_W-1:0]    queue_count,
  output logic [1:0]                   status
);

  localparam int NE = bpq_pkg::NUM_ELEMENTS;
  localparam int NP = bpq_pkg::NUM_PRIORITIES;
  localparam int EW = bpq_pkg::ELEM_W;
  localparam int LW = bpq_pkg::LINK_W;
  localparam int PW = bpq_pkg::PRIO_W;
  localparam int BW = bpq_pkg::EB_W;
  localparam int CW = bpq_pkg::CNT_W;

  // Memories.
  logic [LW-1:0] head_mem [NP];
  logic [LW-1:0] tail_mem [NP];
  logic [LW-1:0] next_mem [NE];
  logic [LW-1:0] prev_mem [NE];
  logic [BW-1:0] eb_mem   [NE];

  logic [LW-1:0] head_rd, tail_rd, next_rd, prev_rd;
  logic [BW-1:0] eb_rd;

  // Item registers.
  logic [EW-1:0] id;
  logic [PW-1:0] pr;
  logic [PW-1:0] src;
  logic [EW-1:0] u;
  logic [PW-1:0] b;
  logic [BW-1:0] qb;
  logic          res_v;
  logic [1:0]    st;
  logic [PW-1:0] max_pri;
  logic [CW-1:0] count;
  logic [CW-1:0] clr_idx;
  logic [NP-1:0] bitmap;

  // Source bucket chosen at capture.
  logic [PW-1:0] src_in;
  always_comb begin
    case (cmd.src_sel)
      bpq_pkg::SRC_MIN: src_in = bpq_pkg::lowest_set(bitmap);
      bpq_pkg::SRC_MAX: src_in = bpq_pkg::highest_set(bitmap);
      default:          src_in = priority_value;
    endcase
  end

  assign stat.id_queued  = !eb_rd[BW-1];
  assign stat.pr_ok      = (pr <= max_pri);
  assign stat.src_empty  = !bitmap[src];
  assign stat.clear_done = clr_idx[CW-1];
  assign stat.out_busy   = out_valid && out_stall;

  // Write ports, one per memory.
  logic          head_we, tail_we, next_we, prev_we, eb_we;
  logic [PW-1:0] head_wa, tail_wa;
  logic [EW-1:0] next_wa, prev_wa, eb_wa;
  logic [LW-1:0] head_wd, tail_wd, next_wd, prev_wd;
  logic [BW-1:0] eb_wd;
  logic          pv_nil, nx_nil, t_nil;
  logic [LW-1:0] t, id_link;

  always_comb begin
    pv_nil  = prev_rd[LW-1];
    nx_nil  = next_rd[LW-1];
    t       = bitmap[pr] ? tail_rd : bpq_pkg::NIL_LINK;
    t_nil   = t[LW-1];
    id_link = {1'b0, id};
    head_we = 1'b0; head_wa = b; head_wd = next_rd;
    tail_we = 1'b0; tail_wa = b; tail_wd = prev_rd;
    next_we = 1'b0; next_wa = prev_rd[EW-1:0]; next_wd = next_rd;
    prev_we = 1'b0; prev_wa = next_rd[EW-1:0]; prev_wd = prev_rd;
    eb_we   = 1'b0; eb_wa = u; eb_wd = bpq_pkg::NIL_BUCKET;
    if (cmd.clr_write) begin
      eb_we = 1'b1;
      eb_wa = clr_idx[EW-1:0];
    end
    // Unlink: bridge the neighbors of the removed element.
    if (cmd.ul_write) begin
      head_we = pv_nil;
      next_we = !pv_nil;
      tail_we = nx_nil;
      prev_we = !nx_nil;
      eb_we   = 1'b1;
    end
    // First link step: the new element ends its list.
    if (cmd.lk_read) begin
      next_we = 1'b1;
      next_wa = id;
      next_wd = bpq_pkg::NIL_LINK;
    end
    // Second link step: append at the tail of the bucket.
    if (cmd.lk_write) begin
      prev_we = 1'b1; prev_wa = id; prev_wd = t;
      head_we = t_nil; head_wa = pr; head_wd = id_link;
      next_we = !t_nil; next_wa = t[EW-1:0]; next_wd = id_link;
      tail_we = 1'b1; tail_wa = pr; tail_wd = id_link;
      eb_we   = 1'b1; eb_wa = id; eb_wd = {1'b0, pr};
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd.capture) head_rd <= head_mem[src_in];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (cmd.lk_read) tail_rd <= tail_mem[pr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd.ul_read) next_rd <= next_mem[u];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd.ul_read) prev_rd <= prev_mem[u];
  end

  always_ff @(posedge clk) begin
    if (eb_we) eb_mem[eb_wa] <= eb_wd;
    if (cmd.capture) eb_rd <= eb_mem[element_id];
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id  <= element_id;
      pr  <= priority_value;
      src <= src_in;
    end
    if (cmd.decide) begin
      u  <= cmd.ul_head ? head_rd[EW-1:0] : id;
      b  <= cmd.ul_head ? src : eb_rd[PW-1:0];
      qb <= eb_rd;
      st <= cmd.st;
    end
    if (cmd.ul_write && (u == id)) qb <= bpq_pkg::NIL_BUCKET;
    if (cmd.lk_write) qb <= {1'b0, pr};
  end

  // Control registers: occupancy, count, clearing pass, extract flag, priority limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap  <= '0;
      count   <= '0;
      clr_idx <= '0;
      res_v   <= 1'b0;
      max_pri <= PW'(NP - 1);
    end else begin
      if (cfg_valid) max_pri <= cfg_data;
      if (cmd.clr_write) clr_idx <= clr_idx + CW'(1);
      if (cmd.decide) res_v <= cmd.ul_head;
      if (cmd.ul_write) begin
        count <= count - CW'(1);
        if (pv_nil && nx_nil) bitmap[b] <= 1'b0;
      end
      if (cmd.lk_write) begin
        count      <= count + CW'(1);
        bitmap[pr] <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_element   <= res_v ? u : '0;
      result_valid     <= res_v;
      element_queued   <= !qb[BW-1];
      element_priority <= qb[BW-1] ? '0 : qb[PW-1:0];
      queue_count      <= count;
      status           <= st;
    end
  end

endmodule

// File: rtl/bucket_priority_queue.sv
// Top level of the bucket priority queue: controller and datapath.
// The time from the input transfer to the result is set by the
// linked-list read-modify-write steps (update key takes the longest path).
// One request is worked at a time; a new request is taken while
// the previous result waits in the output register.
// Reset: synchronous; a clearing pass marks every element
// as not queued, with in_stall high, before the first request is taken.
`timescale 1ns / 1ps

module bucket_priority_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 req_type,
  input  logic [bpq_pkg::ELEM_W-1:0] element_id,
  input  logic [bpq_pkg::PRIO_W-1:0] priority_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bpq_pkg::ELEM_W-1:0] result_element,
  output logic                       result_valid,
  output logic [bpq_pkg::PRIO_W-1:0] element_priority,
  output logic                       element_queued,
  output logic [bpq_pkg::CNT_W-1:0]  queue_count,
  output logic [1:0]                 status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bpq_pkg::PRIO_W-1:0] cfg_data
);

  bpq_pkg::bpq_cmd_t  cmd;
  bpq_pkg::bpq_stat_t stat;

  // The register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  bpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpq_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .element_id       (element_id),
    .priority_value   (priority_value),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_element   (result_element),
    .result_valid     (result_valid),
    .element_priority (element_priority),
    .element_queued   (element_queued),
    .queue_count      (queue_count),
    .status           (status)
  );

endmodule

// File: rtl/bpq_checker.sv
// Port-level checks of the bucket priority queue and their binding.
`timescale 1ns / 1ps

module bpq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  result_element,
  input logic        result_valid,
  input logic [5:0]  element_priority,
  input logic        element_queued,
  input logic [10:0] queue_count,
  input logic [1:0]  status
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_element))
    else $error("stalled result changed");

  // An extracted element comes only with status ok.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_valid |-> status == bpq_pkg::ST_OK)
    else $error("extract with bad status");

  // An element that is not queued reports priority zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !element_queued |-> element_priority == '0)
    else $error("priority of unqueued element");

  // The count never exceeds the number of elements.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> queue_count <= 11'(bpq_pkg::NUM_ELEMENTS))
    else $error("count overflow");

  // The clearing pass after reset holds off requests.
  assert property (@(posedge clk) rst |=> in_stall)
    else $error("request taken during clearing pass");

endmodule

bind bucket_priority_queue bpq_checker u_bpq_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .result_element   (result_element),
  .result_valid     (result_valid),
  .element_priority (element_priority),
  .element_queued   (element_queued),
  .queue_count      (queue_count),
  .status           (status)
);

// File: tb/bpq_checker.sv
// Checker for the bucket priority queue: watches the channels, predicts each result and compares.
`timescale 1ns / 1ps

module bpq_scoreboard
  import bpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [ELEM_W-1:0] element_id,
  input  logic [PRIO_W-1:0] priority_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ELEM_W-1:0] result_element,
  input  logic              result_valid,
  input  logic [PRIO_W-1:0] element_priority,
  input  logic              element_queued,
  input  logic [CNT_W-1:0]  queue_count,
  input  logic [1:0]        status,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [PRIO_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              elem_valid;
    logic [PRIO_W-1:0] prio;
    logic              queued;
    logic [CNT_W-1:0]  count;
    status_t           st;
  } reply_t;

  localparam int DUE_DEPTH = 16;

  // Shadow copy of the bucket lists.
  int          head_of[NUM_PRIORITIES];
  int          tail_of[NUM_PRIORITIES];
  int          next_of[NUM_ELEMENTS];
  int          prev_of[NUM_ELEMENTS];
  int          bucket_of[NUM_ELEMENTS];
  int          total;
  int          prio_limit;

  // Ring of replies that are still owed by the block.
  reply_t      due_buf[DUE_DEPTH];
  int          due_wr;
  int          due_rd;

  assign pending = due_wr - due_rd;

  function automatic bit prio_accepted(int p);
    return p <= prio_limit && p < NUM_PRIORITIES;
  endfunction

  function automatic void append_to_bucket(int e, int p);
    prev_of[e] = tail_of[p];
    next_of[e] = NUM_ELEMENTS;
    if (tail_of[p] == NUM_ELEMENTS) head_of[p] = e;
    else next_of[tail_of[p]] = e;
    tail_of[p] = e;
    bucket_of[e] = p;
    total++;
  endfunction

  function automatic void take_out(int e);
    int b;
    b = bucket_of[e];
    if (b >= NUM_PRIORITIES) return;
    if (prev_of[e] == NUM_ELEMENTS) head_of[b] = next_of[e];
    else next_of[prev_of[e]] = next_of[e];
    if (next_of[e] == NUM_ELEMENTS) tail_of[b] = prev_of[e];
    else prev_of[next_of[e]] = prev_of[e];
    bucket_of[e] = NUM_PRIORITIES;
    total--;
  endfunction

  // Works out the reply to one request and updates the shadow lists.
  function automatic reply_t apply_request(req_t req, int id, int pr);
    reply_t r;
    int     src;
    int     p;
    r = '0;
    r.st = ST_OK;
    src = NUM_PRIORITIES;
    case (req)
      REQ_INSERT: begin
        if (!prio_accepted(pr)) r.st = ST_RANGE;
        else if (bucket_of[id] != NUM_PRIORITIES) r.st = ST_QUEUED;
        else append_to_bucket(id, pr);
      end
      REQ_REMOVE: take_out(id);
      REQ_UPDATE: begin
        if (!prio_accepted(pr)) r.st = ST_RANGE;
        else begin
          take_out(id);
          append_to_bucket(id, pr);
        end
      end
      REQ_EXT_MIN, REQ_EXT_MAX: begin
        for (p = 0; p < NUM_PRIORITIES; p++) begin
          if (head_of[p] != NUM_ELEMENTS) begin
            if (req == REQ_EXT_MAX || src == NUM_PRIORITIES) src = p;
          end
        end
        if (src == NUM_PRIORITIES) r.st = ST_EMPTY;
      end
      REQ_EXT_AT: begin
        if (!prio_accepted(pr)) r.st = ST_RANGE;
        else if (head_of[pr] == NUM_ELEMENTS) r.st = ST_EMPTY;
        else src = pr;
      end
      default: ;
    endcase
    if (src < NUM_PRIORITIES) begin
      r.elem = ELEM_W'(head_of[src]);
      r.elem_valid = 1'b1;
      take_out(head_of[src]);
    end
    if (bucket_of[id] < NUM_PRIORITIES) begin
      r.queued = 1'b1;
      r.prio = PRIO_W'(bucket_of[id]);
    end
    r.count = CNT_W'(total);
    return r;
  endfunction

  // Tracks configuration and request transfers, and checks every result transfer.
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
        head_of[p] = NUM_ELEMENTS;
        tail_of[p] = NUM_ELEMENTS;
      end
      for (int e = 0; e < NUM_ELEMENTS; e++) begin
        bucket_of[e] = NUM_PRIORITIES;
        next_of[e] = 0;
        prev_of[e] = 0;
      end
      total = 0;
      prio_limit = NUM_PRIORITIES - 1;
      due_wr = 0;
      due_rd = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) prio_limit = cfg_data;
      if (in_valid && !in_stall) begin
        due_buf[due_wr % DUE_DEPTH] = apply_request(req_t'(req_type), element_id,
                                                    priority_value);
        due_wr++;
      end
      if (out_valid && !out_stall) begin
        got = {result_element, result_valid, element_priority, element_queued,
               queue_count, status_t'(status)};
        if (due_wr == due_rd) begin
          fail_count++;
          if (fail_count <= 10) $display("result transfer with nothing expected: %p", got);
        end else begin
          want = due_buf[due_rd % DUE_DEPTH];
          due_rd++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("result differs: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_bucket_priority_queue.sv
// Testbench top of the bucket priority queue: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_bucket_priority_queue;
  import bpq_pkg::*;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        req_type;
  logic [ELEM_W-1:0] element_id;
  logic [PRIO_W-1:0] priority_value;
  logic              out_valid;
  logic              out_stall;
  logic [ELEM_W-1:0] result_element;
  logic              result_valid;
  logic [PRIO_W-1:0] element_priority;
  logic              element_queued;
  logic [CNT_W-1:0]  queue_count;
  logic [1:0]        status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [PRIO_W-1:0] cfg_data;
  int                fail_count;
  int                pending;
  int                prio_limit;
  int                sent;
  bit                no_idle;

  bucket_priority_queue u_top (.*);

  bpq_scoreboard u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: holds the result stalled for a random gap before each result transfer.
  initial begin
    int n;
    bit seen;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        seen = out_valid;
        @(posedge clk);
      end while (!seen);
    end
  end

  // Sends one request after a random gap and holds it until the transfer.
  task automatic send_request(req_t req, int id, int pr);
    int gap;
    bit stalled;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    element_id <= ELEM_W'(id);
    priority_value <= PRIO_W'(pr);
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  // Lets every expected result drain, then writes the priority limit.
  task automatic set_limit(int v);
    bit ready_seen;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= PRIO_W'(v);
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    prio_limit = v;
  endtask

  // Random requests, mostly on a small pool of ids so lists grow and shrink.
  task automatic random_requests(int count);
    int r;
    int id;
    int pr;
    req_t req;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 30) req = REQ_INSERT;
      else if (r < 40) req = REQ_REMOVE;
      else if (r < 55) req = REQ_UPDATE;
      else if (r < 65) req = REQ_EXT_MIN;
      else if (r < 75) req = REQ_EXT_MAX;
      else if (r < 85) req = REQ_EXT_AT;
      else if (r < 97) req = REQ_QUERY;
      else req = REQ_NONE;
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 47);
      pr = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, prio_limit);
      send_request(req, id, pr);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_NONE;
    element_id = '0;
    priority_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    prio_limit = 63;
    sent = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, every request type and the corner cases.
    set_limit(63);
    send_request(REQ_EXT_MIN, 0, 0);
    send_request(REQ_EXT_MAX, 0, 0);
    send_request(REQ_INSERT, 0, 0);
    send_request(REQ_INSERT, 1023, 63);
    send_request(REQ_INSERT, 0, 5);
    send_request(REQ_INSERT, 682, 42);
    send_request(REQ_INSERT, 341, 21);
    send_request(REQ_INSERT, 5, 63);
    send_request(REQ_QUERY, 1023, 0);
    send_request(REQ_QUERY, 7, 0);
    send_request(REQ_EXT_AT, 0, 30);
    send_request(REQ_EXT_AT, 0, 63);
    send_request(REQ_REMOVE, 9, 0);
    send_request(REQ_UPDATE, 9, 42);
    send_request(REQ_UPDATE, 341, 0);
    send_request(REQ_NONE, 1023, 63);
    send_request(REQ_EXT_MIN, 0, 0);
    send_request(REQ_EXT_MAX, 0, 0);
    send_request(REQ_INSERT, 100, 50);
    set_limit(0);
    send_request(REQ_INSERT, 11, 1);
    send_request(REQ_UPDATE, 682, 63);
    send_request(REQ_EXT_AT, 0, 42);
    send_request(REQ_EXT_MAX, 0, 0);
    send_request(REQ_REMOVE, 100, 0);

    // Random phases under several limits; a lowered limit strands high buckets.
    random_requests(300);
    set_limit(37);
    random_requests(350);
    set_limit(63);
    random_requests(400);
    set_limit(10);
    random_requests(200);
    set_limit(63);
    random_requests(200);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d requests of every type under priority limits 63, 0, 37 and 10,", sent);
    $display("with random gaps and result stalls; %0d results differed.", fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
